[rtl/trta_pkg.sv]
package trta_pkg;

	localparam int unsigned RAW_W   = 16;
	localparam int unsigned MAG_W   = 13;
	localparam int unsigned MULT_W  = 6;
	localparam int unsigned PROD_W  = MAG_W + MULT_W;
	localparam int unsigned VAL_W   = 16;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned CHAR_W  = 7;

	// 3125/1000 = 25/8 and 5625/1000 = 45/8: divide by 1000 becomes a shift by 3
	localparam logic [MULT_W-1:0] MULT_C = 6'd25;
	localparam logic [MULT_W-1:0] MULT_F = 6'd45;
	// remainder (p mod 8) * 125 exceeds 500 when p mod 8 exceeds this
	localparam logic [2:0]        ROUND_LIMIT = 3'd4;
	localparam logic [VAL_W-1:0]  F_OFFSET    = 16'd3200;

	localparam int unsigned W_TEN_THOUSANDS = 10000;
	localparam int unsigned W_THOUSANDS     = 1000;
	localparam int unsigned W_HUNDREDS      = 100;
	localparam int unsigned W_TENS          = 10;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'h39;
	localparam logic [CHAR_W-1:0] ASCII_POINT = 7'h2E;
	localparam logic [CHAR_W-1:0] ASCII_SPACE = 7'h20;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

	function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
		return ASCII_ZERO + CHAR_W'(d);
	endfunction

endpackage

[rtl/trta_digit.sv]
// One decimal digit: value / WEIGHT and value % WEIGHT by parallel compares.
// Requires value < 10 * WEIGHT.
module trta_digit #(
	parameter int unsigned IN_W   = trta_pkg::VAL_W,
	parameter int unsigned WEIGHT = trta_pkg::W_TEN_THOUSANDS,
	localparam int unsigned REM_W = $clog2(WEIGHT)
) (
	input  logic [IN_W-1:0]              value,
	output logic [trta_pkg::DIGIT_W-1:0] digit,
	output logic [REM_W-1:0]             rest
);

	logic [31:0] value_ext;

	assign value_ext = 32'(value);

	always_comb begin
		digit = '0;
		rest  = REM_W'(value_ext);
		for (int k = 1; k <= 9; k++) begin
			if (value_ext >= 32'(k * WEIGHT)) begin
				digit = trta_pkg::DIGIT_W'(k);
				rest  = REM_W'(value_ext - 32'(k * WEIGHT));
			end
		end
	end

endmodule

[rtl/temp_reading_to_ascii_decimal_core.sv]
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------------
// in       | in_valid / in_ready   | raw_reading[15:0]
// out      | out_valid / out_ready | char_top, char_tens, char_units,
//          |                       | char_point, char_tenths, char_hundredths
// cfg      | cfg_valid / cfg_ready | fahrenheit (cfg_ready always high)
//
// Seven-stage pipeline: scale multiply, round and offset, then one decimal
// digit per stage; one item per cycle while no result waits on out_ready.
// All stages advance together while the output register is empty or taken;
// in_ready is low only while a result waits on out_ready.
// arst_n clears the valid bits and fahrenheit (Celsius); payload is not reset.
module temp_reading_to_ascii_decimal_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        fahrenheit,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [trta_pkg::RAW_W-1:0]  raw_reading,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [trta_pkg::CHAR_W-1:0] char_hundredths,
	output logic [trta_pkg::CHAR_W-1:0] char_tenths,
	output logic [trta_pkg::CHAR_W-1:0] char_point,
	output logic [trta_pkg::CHAR_W-1:0] char_units,
	output logic [trta_pkg::CHAR_W-1:0] char_tens,
	output logic [trta_pkg::CHAR_W-1:0] char_top
);

	localparam int unsigned R4_W = $clog2(trta_pkg::W_TEN_THOUSANDS);
	localparam int unsigned R3_W = $clog2(trta_pkg::W_THOUSANDS);
	localparam int unsigned R2_W = $clog2(trta_pkg::W_HUNDREDS);
	localparam int unsigned R1_W = $clog2(trta_pkg::W_TENS);

	logic fahrenheit_q;
	logic adv;

	logic                         v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [trta_pkg::RAW_W-1:0]   raw_s1;
	logic                         f_s1, f_s2;
	logic                         neg_s2;
	logic [trta_pkg::PROD_W-1:0]  prod_s2;
	logic [trta_pkg::VAL_W-1:0]   val_s3;
	logic                         minus_s3, minus_s4, minus_s5, minus_s6;
	logic [trta_pkg::DIGIT_W-1:0] d4_s4, d4_s5, d4_s6;
	logic [trta_pkg::DIGIT_W-1:0] d3_s5, d3_s6;
	logic [trta_pkg::DIGIT_W-1:0] d2_s6;
	logic [R4_W-1:0]              rem_s4;
	logic [R3_W-1:0]              rem_s5;
	logic [R2_W-1:0]              rem_s6;

	logic [trta_pkg::MAG_W-1:0]   mag;
	logic [trta_pkg::PROD_W-1:0]  prod;
	logic [trta_pkg::VAL_W-1:0]   quot;
	logic [trta_pkg::VAL_W-1:0]   val;
	logic                         minus;
	logic [trta_pkg::DIGIT_W-1:0] d4, d3, d2, d1;
	logic [R4_W-1:0]              rem4;
	logic [R3_W-1:0]              rem3;
	logic [R2_W-1:0]              rem2;
	logic [R1_W-1:0]              rem1;

	assign cfg_ready = 1'b1;
	assign adv       = !v_s7 || out_ready;
	assign in_ready  = adv;
	assign out_valid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fahrenheit_q <= 1'b0;
		end else if (cfg_valid) begin
			fahrenheit_q <= fahrenheit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Magnitude in 1/32 degree steps; a negative word is two's-complemented.
	assign mag  = raw_s1[trta_pkg::RAW_W-1] ?
		trta_pkg::MAG_W'(~raw_s1[14:2] + 13'd1) : raw_s1[14:2];
	assign prod = trta_pkg::PROD_W'(mag) *
		trta_pkg::PROD_W'(f_s1 ? trta_pkg::MULT_F : trta_pkg::MULT_C);

	// Drop three bits for the divide by 1000, round up past half.
	always_comb begin
		quot = trta_pkg::VAL_W'(prod_s2[trta_pkg::PROD_W-1:3]) +
			trta_pkg::VAL_W'(prod_s2[2:0] > trta_pkg::ROUND_LIMIT);
		val   = quot;
		minus = neg_s2;
		if (f_s2) begin
			if (!neg_s2) begin
				val   = trta_pkg::F_OFFSET + quot;
				minus = 1'b0;
			end else if (quot > trta_pkg::F_OFFSET) begin
				val   = quot - trta_pkg::F_OFFSET;
				minus = 1'b1;
			end else begin
				val   = trta_pkg::F_OFFSET - quot;
				minus = 1'b0;
			end
		end
	end

	trta_digit #(.IN_W(trta_pkg::VAL_W), .WEIGHT(trta_pkg::W_TEN_THOUSANDS)) u_dig4 (
		.value(val_s3), .digit(d4), .rest(rem4)
	);
	trta_digit #(.IN_W(R4_W), .WEIGHT(trta_pkg::W_THOUSANDS)) u_dig3 (
		.value(rem_s4), .digit(d3), .rest(rem3)
	);
	trta_digit #(.IN_W(R3_W), .WEIGHT(trta_pkg::W_HUNDREDS)) u_dig2 (
		.value(rem_s5), .digit(d2), .rest(rem2)
	);
	trta_digit #(.IN_W(R2_W), .WEIGHT(trta_pkg::W_TENS)) u_dig1 (
		.value(rem_s6), .digit(d1), .rest(rem1)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s1   <= raw_reading;
			f_s1     <= fahrenheit_q;

			prod_s2  <= prod;
			neg_s2   <= raw_s1[trta_pkg::RAW_W-1];
			f_s2     <= f_s1;

			val_s3   <= val;
			minus_s3 <= minus;

			d4_s4    <= d4;
			rem_s4   <= rem4;
			minus_s4 <= minus_s3;

			d4_s5    <= d4_s4;
			d3_s5    <= d3;
			rem_s5   <= rem3;
			minus_s5 <= minus_s4;

			d4_s6    <= d4_s5;
			d3_s6    <= d3_s5;
			d2_s6    <= d2;
			rem_s6   <= rem2;
			minus_s6 <= minus_s5;

			char_hundredths <= trta_pkg::to_ascii(trta_pkg::DIGIT_W'(rem1));
			char_tenths     <= trta_pkg::to_ascii(d1);
			char_point      <= trta_pkg::ASCII_POINT;
			char_units      <= trta_pkg::to_ascii(d2_s6);
			char_tens       <= trta_pkg::to_ascii(d3_s6);
			if (minus_s6) begin
				char_top <= trta_pkg::ASCII_MINUS;
			end else if (d4_s6 == '0) begin
				char_top <= trta_pkg::ASCII_SPACE;
			end else begin
				char_top <= trta_pkg::to_ascii(d4_s6);
			end
		end
	end

endmodule

[rtl/trta_checker.sv]
module trta_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [trta_pkg::CHAR_W-1:0] char_hundredths,
	input logic [trta_pkg::CHAR_W-1:0] char_tenths,
	input logic [trta_pkg::CHAR_W-1:0] char_point,
	input logic [trta_pkg::CHAR_W-1:0] char_units,
	input logic [trta_pkg::CHAR_W-1:0] char_tens,
	input logic [trta_pkg::CHAR_W-1:0] char_top
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_top) &&
			$stable(char_tens) && $stable(char_units) && $stable(char_tenths) &&
			$stable(char_hundredths))
		else $error("stalled result changed");

	// an empty output register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> char_point == trta_pkg::ASCII_POINT)
		else $error("decimal point slot wrong");

	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> char_hundredths >= trta_pkg::ASCII_ZERO &&
			char_hundredths <= trta_pkg::ASCII_NINE &&
			char_tenths >= trta_pkg::ASCII_ZERO && char_tenths <= trta_pkg::ASCII_NINE &&
			char_units >= trta_pkg::ASCII_ZERO && char_units <= trta_pkg::ASCII_NINE &&
			char_tens >= trta_pkg::ASCII_ZERO && char_tens <= trta_pkg::ASCII_NINE)
		else $error("digit slot not a decimal digit");

	a_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> char_top == trta_pkg::ASCII_SPACE ||
			char_top == trta_pkg::ASCII_MINUS ||
			(char_top > trta_pkg::ASCII_ZERO && char_top <= trta_pkg::ASCII_NINE))
		else $error("top slot holds a leading zero or bad code");

endmodule

bind temp_reading_to_ascii_decimal_core trta_checker u_trta_checker (.*);
